// ===== src/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// Types, constants and helpers shared by the medoid selection block.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int DEF_MAX_DESCS = 64;
    localparam int DEF_WORDS     = 4;
    localparam int WORD_W        = 64;
    localparam int SEL_W         = 3;
    localparam int POP_W         = 7;
    localparam int INDEX_OUT_W   = 6;
    localparam int SUM_OUT_W     = 14;
    localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_STREAM,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [SEL_W-1:0]  k;
        logic [WORD_W-1:0] data;
    } t_stream;

    typedef struct packed {
        logic vld;
        logic have;
    } t_best;

    typedef struct packed {
        logic              acc_clr;
        logic              wfirst;
        logic [SEL_W-1:0]  wsel;
        logic [WORD_W-1:0] wdata;
    } t_cell_ctl;

    function automatic logic [POP_W-1:0] popcount64(logic [WORD_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int n = 0; n < 32; n++) l1[n] = {1'b0, v[2*n]} + {1'b0, v[2*n+1]};
        for (int n = 0; n < 16; n++) l2[n] = {1'b0, l1[2*n]} + {1'b0, l1[2*n+1]};
        for (int n = 0; n < 8; n++)  l3[n] = {1'b0, l2[2*n]} + {1'b0, l2[2*n+1]};
        for (int n = 0; n < 4; n++)  l4[n] = {1'b0, l3[2*n]} + {1'b0, l3[2*n+1]};
        for (int n = 0; n < 2; n++)  l5[n] = {1'b0, l4[2*n]} + {1'b0, l4[2*n+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

// ===== src/hms_in_if.sv =====
// ----------------------------------------------------------------------------
// hms_in_if
// Descriptor word channel: valid/ready with word and end-of-set flag.
// ----------------------------------------------------------------------------
interface hms_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] desc_word;
    logic        set_last;

    modport source (output valid, output desc_word, output set_last, input ready);
    modport sink   (input valid, input desc_word, input set_last, output ready);
endinterface

// ===== src/hms_out_if.sv =====
// ----------------------------------------------------------------------------
// hms_out_if
// Result channel: valid/ready with one word of the selected descriptor.
// ----------------------------------------------------------------------------
interface hms_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] best_word;
    logic [5:0]  best_index;
    logic [13:0] best_distance_sum;
    logic        overflow;
    logic        out_last;

    modport source (output valid, output best_word, output best_index,
                    output best_distance_sum, output overflow, output out_last,
                    input ready);
    modport sink   (input valid, input best_word, input best_index,
                    input best_distance_sum, input overflow, input out_last,
                    output ready);
endinterface

// ===== src/hms_ram.sv =====
// ----------------------------------------------------------------------------
// hms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hms_cell.sv =====
// ----------------------------------------------------------------------------
// hms_cell
// One descriptor slot: holds its descriptor, sums distances to the words
// streaming past, and joins the running minimum as the scan item passes.
// ----------------------------------------------------------------------------
module hms_cell
    import hms_pkg::*;
#(
    parameter int WORDS = DEF_WORDS,
    parameter int IDX   = 0,
    parameter int ACC_W = 17,
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_we,
    input  logic             i_active,
    input  t_stream          i_strm,
    output t_stream          o_strm,
    input  t_best            i_bt,
    input  logic [ACC_W-1:0] i_bsum,
    input  logic [IDX_W-1:0] i_bidx,
    output t_best            o_bt,
    output logic [ACC_W-1:0] o_bsum,
    output logic [IDX_W-1:0] o_bidx
);

    localparam int WPW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [WORD_W-1:0] r_word [WORDS];
    logic [ACC_W-1:0]  r_acc;
    t_stream           r_strm;
    t_best             r_bt;
    logic [ACC_W-1:0]  r_bsum;
    logic [IDX_W-1:0]  r_bidx;

    logic [POP_W-1:0]  pop;
    logic              take;

    assign pop  = popcount64(i_strm.data ^ r_word[i_strm.k[WPW-1:0]]);
    assign take = i_bt.vld && i_active && (!i_bt.have || (r_acc < i_bsum));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int w = 0; w < WORDS; w++) begin
                if (i_ctl.wfirst) begin
                    r_word[w] <= '0;
                end
            end
            r_word[i_ctl.wsel[WPW-1:0]] <= i_ctl.wdata;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_strm.vld) begin
            r_acc <= r_acc + ACC_W'(pop);
        end
        r_strm.k    <= i_strm.k;
        r_strm.data <= i_strm.data;
        r_bt.have   <= i_bt.have | take;
        r_bsum      <= take ? r_acc : i_bsum;
        r_bidx      <= take ? IDX_W'(IDX) : i_bidx;
        if (!i_rst_n) begin
            r_strm.vld <= 1'b0;
            r_bt.vld   <= 1'b0;
        end else begin
            r_strm.vld <= i_strm.vld;
            r_bt.vld   <= i_bt.vld;
        end
    end

    assign o_strm = r_strm;
    assign o_bt   = r_bt;
    assign o_bsum = r_bsum;
    assign o_bidx = r_bidx;

endmodule

// ===== src/hamming_medoid_select.sv =====
// ----------------------------------------------------------------------------
// hamming_medoid_select
// Medoid selection over a set of binary descriptors by summed Hamming distance.
// ----------------------------------------------------------------------------
// Usage:
//   i_desc takes one 64-bit descriptor word per item, lowest word first,
//   WORDS_PER_DESC words per descriptor. set_last closes the set; a partial
//   last descriptor is zero filled, descriptors past MAX_DESCS are dropped
//   and flagged in overflow.
//   o_best then returns WORDS_PER_DESC items: the medoid's words with its
//   index and distance sum, out_last on the final word.
//   While i_desc.ready is high, loading takes one item per cycle. After
//   set_last the block is busy with any zero fill, streaming every stored
//   word past the row of MAX_DESCS cells, the minimum travelling the row,
//   and a read of the store for each result word. The single read port of
//   the word store sets the streaming time. i_desc.ready is low from
//   set_last until the last result is taken.
//   A stalled receiver holds the current result; nothing is lost.
//   Reset empties the set; the word store itself is not cleared.
// ----------------------------------------------------------------------------
module hamming_medoid_select
    import hms_pkg::*;
#(
    parameter int MAX_DESCS      = DEF_MAX_DESCS,
    parameter int WORDS_PER_DESC = DEF_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hms_in_if.sink    i_desc,
    hms_out_if.source o_best
);

    localparam int WPW   = (WORDS_PER_DESC > 1) ? $clog2(WORDS_PER_DESC) : 1;
    localparam int CW    = $clog2(MAX_DESCS + 1);
    localparam int IW    = $clog2(MAX_DESCS);
    localparam int DEPTH = MAX_DESCS * WORDS_PER_DESC;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = $clog2((MAX_DESCS - 1) * WORD_W * WORDS_PER_DESC + 1);

    t_state            r_state, n_state;
    logic [WPW-1:0]    r_pos, n_pos;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [IW-1:0]     r_j, n_j;
    logic [WPW-1:0]    r_k, n_k;
    logic              r_rd_vld, r_rd_last, r_tok;
    logic [WPW-1:0]    r_rd_k;
    logic [IW-1:0]     r_best_idx;
    logic [ACC_W-1:0]  r_min_sum;
    logic [WORD_W-1:0] r_out_word;

    logic              accept, full, pos_last, k_last, j_last;
    logic              ram_we, rd_issue, strm_last, cell_wr;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    t_cell_ctl         ctl;

    t_stream           strm [MAX_DESCS+1];
    t_best             bt   [MAX_DESCS+1];
    logic [ACC_W-1:0]  bsum [MAX_DESCS+1];
    logic [IW-1:0]     bidx [MAX_DESCS+1];

    assign accept   = i_desc.valid && i_desc.ready;
    assign full     = (r_count == CW'(MAX_DESCS));
    assign pos_last = (r_pos == WPW'(WORDS_PER_DESC - 1));
    assign k_last   = (r_k == WPW'(WORDS_PER_DESC - 1));
    assign j_last   = ((CW'(r_j) + CW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_pos     <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_j       <= '0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_tok     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_j       <= n_j;
            r_k       <= n_k;
            r_rd_vld  <= rd_issue;
            r_rd_last <= rd_issue && strm_last;
            r_tok     <= r_rd_vld && r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (r_state == ST_SCAN && bt[MAX_DESCS].vld) begin
            r_best_idx <= bidx[MAX_DESCS];
            r_min_sum  <= bsum[MAX_DESCS];
        end
        if (r_state == ST_EMIT_WAIT) begin
            r_out_word <= ram_rdata;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_j       = r_j;
        n_k       = r_k;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_count) * AW'(WORDS_PER_DESC) + AW'(r_pos);
        ram_wdata = i_desc.desc_word;
        ram_raddr = AW'(r_j) * AW'(WORDS_PER_DESC) + AW'(r_k);
        rd_issue  = 1'b0;
        strm_last = 1'b0;
        cell_wr   = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (!full) begin
                        ram_we  = 1'b1;
                        cell_wr = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_pos = pos_last ? '0 : r_pos + WPW'(1);
                    if (pos_last && !full) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_desc.set_last) begin
                        n_j = '0;
                        n_k = '0;
                        if (n_pos != '0 && !full) begin
                            n_state = ST_PAD;
                        end else begin
                            n_pos   = '0;
                            n_state = ST_STREAM;
                        end
                    end
                end
            end
            ST_PAD: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (pos_last) begin
                    n_pos   = '0;
                    n_count = r_count + CW'(1);
                    n_state = ST_STREAM;
                end else begin
                    n_pos = r_pos + WPW'(1);
                end
            end
            ST_STREAM: begin
                rd_issue  = 1'b1;
                strm_last = j_last && k_last;
                if (k_last) begin
                    n_k = '0;
                    n_j = r_j + IW'(1);
                end else begin
                    n_k = r_k + WPW'(1);
                end
                if (strm_last) begin
                    n_j     = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (bt[MAX_DESCS].vld) begin
                    n_k     = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                ram_raddr = AW'(r_best_idx) * AW'(WORDS_PER_DESC) + AW'(r_k);
                n_state   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (o_best.ready) begin
                    if (k_last) begin
                        n_k     = '0;
                        n_pos   = '0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + WPW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign i_desc.ready = (r_state == ST_LOAD);

    assign o_best.valid             = (r_state == ST_EMIT_OUT);
    assign o_best.best_word         = r_out_word;
    assign o_best.best_index        = INDEX_OUT_W'(r_best_idx);
    assign o_best.best_distance_sum = (r_min_sum > ACC_W'(SUM_OUT_MAX)) ?
                                      SUM_OUT_MAX : SUM_OUT_W'(r_min_sum);
    assign o_best.overflow          = r_ovf;
    assign o_best.out_last          = k_last;

    hms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ctl.acc_clr = (r_state == ST_LOAD);
    assign ctl.wfirst  = (r_pos == '0);
    assign ctl.wsel    = SEL_W'(r_pos);
    assign ctl.wdata   = i_desc.desc_word;

    assign strm[0].vld  = r_rd_vld;
    assign strm[0].k    = SEL_W'(r_rd_k);
    assign strm[0].data = ram_rdata;
    assign bt[0].vld    = r_tok;
    assign bt[0].have   = 1'b0;
    assign bsum[0]      = '0;
    assign bidx[0]      = '0;

    for (genvar g = 0; g < MAX_DESCS; g++) begin : g_cell
        hms_cell #(
            .WORDS (WORDS_PER_DESC),
            .IDX   (g),
            .ACC_W (ACC_W),
            .IDX_W (IW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_we     (cell_wr && (r_count == CW'(g))),
            .i_active (CW'(g) < r_count),
            .i_strm   (strm[g]),
            .o_strm   (strm[g+1]),
            .i_bt     (bt[g]),
            .i_bsum   (bsum[g]),
            .i_bidx   (bidx[g]),
            .o_bt     (bt[g+1]),
            .o_bsum   (bsum[g+1]),
            .o_bidx   (bidx[g+1])
        );
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hamming_medoid_select. Descriptor sets stream in
// from a queue of pending items. A predictor picks the medoid of each set at
// the set_last item and queues the words due on the result channel. Every
// result item is checked field by field against them. Idling changes phase
// by phase, and the receiver holds off for a long time right after reset.
// ----------------------------------------------------------------------------
module tb
    import hms_pkg::*;
();

    localparam int MAX_D        = DEF_MAX_DESCS;
    localparam int WORDS        = DEF_WORDS;
    localparam int HEAVY_PCT    = 69;
    localparam int LIGHT_PCT    = 14;
    localparam int HOLD_CYCLES  = 400;
    localparam int SMALL_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 2 * MAX_D + 16;
    localparam int RUN_LIMIT    = 400000;
    localparam int REPORT_MAX   = 10;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_idle_phase;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        t_idle_phase       phase;
    } t_desc_item;

    typedef struct packed {
        logic [WORD_W-1:0]      word;
        logic [INDEX_OUT_W-1:0] index;
        logic [SUM_OUT_W-1:0]   sum;
        logic                   ovf;
        logic                   last;
    } t_medoid_word;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              send_valid = 1'b0;
    logic [WORD_W-1:0] send_word  = '0;
    logic              send_last  = 1'b0;
    logic              take_ready = 1'b0;
    t_idle_phase       cur_phase  = PH_STEADY;
    int unsigned       hold_left  = HOLD_CYCLES;
    int unsigned       cycles     = 0;
    int unsigned       mismatches = 0;

    t_desc_item   words_to_send[$];
    t_medoid_word medoid_words_q[$];

    // predictor state: the current set
    logic [WORD_W-1:0] held_desc [MAX_D][WORDS];
    int unsigned       word_slot  = 0;
    int unsigned       descs_held = 0;
    logic              dropped    = 1'b0;

    hms_in_if  desc_if ();
    hms_out_if best_if ();

    assign desc_if.valid     = send_valid;
    assign desc_if.desc_word = send_word;
    assign desc_if.set_last  = send_last;
    assign best_if.ready     = take_ready;

    hamming_medoid_select #(
        .MAX_DESCS      (MAX_D),
        .WORDS_PER_DESC (WORDS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (desc_if),
        .o_best  (best_if)
    );

    function automatic bit idle_roll(t_idle_phase ph, t_idle_phase heavy_ph);
        if (ph == heavy_ph) begin
            return $urandom_range(99) < HEAVY_PCT;
        end
        if (ph == PH_BOTH) begin
            return $urandom_range(99) < LIGHT_PCT;
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(string what, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (mismatches < REPORT_MAX) begin
            $display("tb: %s mismatch: expected %h, got %h", what, want, got);
        end
        mismatches++;
    endfunction

    task automatic push_word(logic [WORD_W-1:0] w, logic last, t_idle_phase ph);
        t_desc_item it;
        it.word  = w;
        it.last  = last;
        it.phase = ph;
        words_to_send = {words_to_send, it};
    endtask

    // half of the words are near copies of a per-set base so that medoids and ties are meaningful
    function automatic logic [WORD_W-1:0] pick_word(logic [WORD_W-1:0] base);
        logic [WORD_W-1:0] flips;
        flips = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom};
            4:       return base;
            default: return base ^ flips;
        endcase
    endfunction

    task automatic add_set(int unsigned n_words, t_idle_phase ph);
        logic [WORD_W-1:0] base [WORDS];
        for (int k = 0; k < WORDS; k++) begin
            base[k] = {$urandom, $urandom};
        end
        for (int unsigned w = 0; w < n_words; w++) begin
            push_word(pick_word(base[w % WORDS]), w == n_words - 1, ph);
        end
    endtask

    task automatic predict_word(logic [WORD_W-1:0] w, logic last);
        int unsigned  best;
        int unsigned  min_sum;
        int unsigned  sum;
        t_medoid_word r;
        if (descs_held < MAX_D) begin
            held_desc[descs_held][word_slot] = w;
        end else begin
            dropped = 1'b1;
        end
        word_slot++;
        if (word_slot == WORDS) begin
            word_slot = 0;
            if (descs_held < MAX_D) descs_held++;
        end
        if (!last) return;

        // partial last descriptor: zero fill
        if (word_slot != 0 && descs_held < MAX_D) begin
            for (int unsigned k = word_slot; k < WORDS; k++) begin
                held_desc[descs_held][k] = '0;
            end
            descs_held++;
        end

        best    = 0;
        min_sum = 0;
        for (int unsigned i = 0; i < descs_held; i++) begin
            sum = 0;
            for (int unsigned j = 0; j < descs_held; j++) begin
                if (i != j) begin
                    for (int k = 0; k < WORDS; k++) begin
                        sum += $countones(held_desc[i][k] ^ held_desc[j][k]);
                    end
                end
            end
            if (i == 0 || sum < min_sum) begin
                best    = i;
                min_sum = sum;
            end
        end

        for (int k = 0; k < WORDS; k++) begin
            r.word  = held_desc[best][k];
            r.index = best[INDEX_OUT_W-1:0];
            r.sum   = (min_sum > SUM_OUT_MAX) ? SUM_OUT_MAX : min_sum[SUM_OUT_W-1:0];
            r.ovf   = dropped;
            r.last  = (k == WORDS - 1);
            medoid_words_q = {medoid_words_q, r};
        end
        word_slot  = 0;
        descs_held = 0;
        dropped    = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : send_words
        t_desc_item nxt;
        if (!i_rst_n) begin
            send_valid <= 1'b0;
        end else begin
            if (send_valid && desc_if.ready) begin
                predict_word(send_word, send_last);
            end
            if (!send_valid || desc_if.ready) begin
                if (words_to_send.size() != 0 &&
                    !idle_roll(words_to_send[0].phase, PH_SRC_IDLE)) begin
                    nxt = words_to_send.pop_front();
                    send_valid <= 1'b1;
                    send_word  <= nxt.word;
                    send_last  <= nxt.last;
                    cur_phase  <= nxt.phase;
                end else begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : take_results
        t_medoid_word want;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (take_ready && best_if.valid) begin
                if (medoid_words_q.size() == 0) begin
                    note_mismatch("unexpected item", '0, best_if.best_word);
                end else begin
                    want = medoid_words_q.pop_front();
                    if (best_if.best_word !== want.word)
                        note_mismatch("best_word", want.word, best_if.best_word);
                    if (best_if.best_index !== want.index)
                        note_mismatch("best_index", WORD_W'(want.index),
                                      WORD_W'(best_if.best_index));
                    if (best_if.best_distance_sum !== want.sum)
                        note_mismatch("best_distance_sum", WORD_W'(want.sum),
                                      WORD_W'(best_if.best_distance_sum));
                    if (best_if.overflow !== want.ovf)
                        note_mismatch("overflow", WORD_W'(want.ovf),
                                      WORD_W'(best_if.overflow));
                    if (best_if.out_last !== want.last)
                        note_mismatch("out_last", WORD_W'(want.last),
                                      WORD_W'(best_if.out_last));
                end
            end
            take_ready <= (hold_left == 0) && !idle_roll(cur_phase, PH_SNK_STALL);
        end
    end

    initial begin : stimulus
        int unsigned done;
        int unsigned n;
        t_idle_phase ph;

        // single word: one zero-filled descriptor, index 0, sum 0
        push_word('1, 1'b1, PH_STEADY);
        // all ones vs all zeros: tie goes to index 0
        for (int k = 0; k < 2 * WORDS; k++) begin
            push_word((k < WORDS) ? '1 : '0, k == 2 * WORDS - 1, PH_STEADY);
        end
        // ones, zeros, alternating: the third one is the medoid
        for (int k = 0; k < 3 * WORDS; k++) begin
            push_word((k < WORDS) ? '1 : (k < 2 * WORDS) ? '0 : 64'h5555_5555_5555_5555,
                      k == 3 * WORDS - 1, PH_STEADY);
        end
        // set ends mid-descriptor
        push_word(64'h8000_0000_0000_0001, 1'b0, PH_STEADY);
        push_word('1, 1'b0, PH_STEADY);
        push_word({$urandom, $urandom}, 1'b0, PH_STEADY);
        push_word('0, 1'b0, PH_STEADY);
        push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, PH_STEADY);
        push_word({$urandom, $urandom}, 1'b1, PH_STEADY);

        done = words_to_send.size();
        while (done < SMALL_ITEMS) begin
            if (done < SMALL_ITEMS / 4)          ph = PH_STEADY;
            else if (done < SMALL_ITEMS / 2)     ph = PH_SRC_IDLE;
            else if (done < 3 * SMALL_ITEMS / 4) ph = PH_SNK_STALL;
            else                                 ph = PH_BOTH;
            n = $urandom_range(1, 6) * WORDS;
            if ($urandom_range(1)) n -= $urandom_range(WORDS - 1);
            add_set(n, ph);
            done += n;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (words_to_send.size() != 0 || send_valid || medoid_words_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && medoid_words_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
